/* design/battery_level_monitor_unit_defines.svh */
// ----------------------------------------------------------------------------
// Battery level monitor assertion macros
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_MONITOR_UNIT_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_UNIT_DEFINES_SVH

// Same-cycle implication: consequent must hold at the edge the antecedent holds.
`define BLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: consequent must hold at the following edge.
`define BLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/blm_pkg.sv */
// ----------------------------------------------------------------------------
// Battery level monitor package
// Shared types, constants and arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package blm_pkg;

    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned CV_W     = 10;
    localparam int unsigned LIMIT_W  = 10;
    localparam int unsigned ZLIM_W   = 8;
    localparam int unsigned RUN_W    = 8;

    // Consecutive qualifying readings needed to settle a status
    localparam int unsigned CONFIRM_COUNT = 3;

    // Full scale: 255 counts map to 660 cV; ratio reduces to 44/17
    localparam int unsigned CV_FULL_SCALE  = 660;
    localparam int unsigned ADC_FULL_SCALE = 255;
    localparam int unsigned SCALE_GCD      = 15;
    localparam int unsigned SCALE_MUL      = CV_FULL_SCALE / SCALE_GCD;
    localparam int unsigned SCALE_DIV      = ADC_FULL_SCALE / SCALE_GCD;
    localparam int unsigned RECIP_SHIFT    = 18;
    localparam int unsigned RECIP_DIV      = ((2 ** RECIP_SHIFT) + SCALE_DIV - 1) / SCALE_DIV;
    localparam int unsigned SCALE_COMBINED = SCALE_MUL * RECIP_DIV;
    localparam int unsigned PROD_W         = 28;

    localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 10'd660;
    localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 10'd360;
    localparam logic [LIMIT_W-1:0] OFF_LIMIT_RST  = 10'd330;
    localparam logic [ZLIM_W-1:0]  ZERO_LIMIT_RST = 8'd3;

    typedef enum logic [1:0] {
        ST_UNDECIDED = 2'd0,
        ST_NORMAL    = 2'd1,
        ST_LOW       = 2'd2
    } t_power_status;

    typedef enum logic [1:0] {
        CFG_HIGH_LIMIT = 2'd0,
        CFG_LOW_LIMIT  = 2'd1,
        CFG_OFF_LIMIT  = 2'd2,
        CFG_ZERO_LIMIT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [LIMIT_W-1:0] high_limit;
        logic [LIMIT_W-1:0] low_limit;
        logic [LIMIT_W-1:0] off_limit;
        logic [ZLIM_W-1:0]  zero_limit;
    } t_limits;

    typedef struct packed {
        logic [CV_W-1:0] battery_centivolts;
        t_power_status   power_status;
        logic            zero_held;
    } t_result;

    // floor(sample * 44 / 17) by reciprocal multiply; exact for all 8-bit inputs
    function automatic logic [CV_W-1:0] adc_to_cv(input logic [SAMPLE_W-1:0] sample);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(sample) * PROD_W'(SCALE_COMBINED);
        return prod[RECIP_SHIFT +: CV_W];
    endfunction

    function automatic logic [RUN_W-1:0] sat_inc(input logic [RUN_W-1:0] v);
        return (v == {RUN_W{1'b1}}) ? v : v + RUN_W'(1);
    endfunction

endpackage

/* design/blm_core.sv */
// ----------------------------------------------------------------------------
// Battery level monitor core
// Converts one sample, applies zero hold and updates the status run counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module blm_core #(
    parameter int unsigned CONFIRM_COUNT = blm_pkg::CONFIRM_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [blm_pkg::SAMPLE_W-1:0]   i_sample,
    input  blm_pkg::t_limits               i_limits,
    output blm_pkg::t_result               o_result
);

    logic [blm_pkg::RUN_W-1:0]  r_zero_run, n_zero_run;
    logic [blm_pkg::CV_W-1:0]   r_held, n_held;
    logic [blm_pkg::RUN_W-1:0]  r_low_run, n_low_run;
    logic [blm_pkg::RUN_W-1:0]  r_normal_run, n_normal_run;
    blm_pkg::t_power_status     r_status, n_status;

    logic [blm_pkg::CV_W-1:0]   w_cv;
    logic [blm_pkg::CV_W-1:0]   w_volts;
    logic [blm_pkg::RUN_W-1:0]  w_zero_inc;
    logic [blm_pkg::RUN_W-1:0]  w_low_inc;
    logic [blm_pkg::RUN_W-1:0]  w_normal_inc;
    logic                       w_held_flag;

    assign w_cv         = blm_pkg::adc_to_cv(i_sample);
    assign w_zero_inc   = blm_pkg::sat_inc(r_zero_run);
    assign w_low_inc    = blm_pkg::sat_inc(r_low_run);
    assign w_normal_inc = blm_pkg::sat_inc(r_normal_run);

    always_comb begin
        n_zero_run   = r_zero_run;
        n_held       = r_held;
        n_low_run    = r_low_run;
        n_normal_run = r_normal_run;
        n_status     = r_status;
        w_volts      = w_cv;
        w_held_flag  = 1'b0;

        // Zero hold: replace a zero reading by the last value until the run is long enough
        if (w_cv == '0) begin
            n_zero_run = w_zero_inc;
            if (w_zero_inc >= i_limits.zero_limit) begin
                n_held = '0;
            end else begin
                w_volts     = r_held;
                w_held_flag = 1'b1;
            end
        end else begin
            n_zero_run = '0;
            n_held     = w_cv;
        end

        // Judge against the limits in fixed order, whatever their relation
        if (w_volts <= i_limits.high_limit) begin
            if (w_volts <= i_limits.low_limit) begin
                n_normal_run = '0;
                if (w_volts > i_limits.off_limit) begin
                    n_low_run = w_low_inc;
                    if (w_low_inc >= blm_pkg::RUN_W'(CONFIRM_COUNT)) begin
                        n_status = blm_pkg::ST_LOW;
                    end
                end
            end else begin
                n_low_run    = '0;
                n_normal_run = w_normal_inc;
                if (w_normal_inc >= blm_pkg::RUN_W'(CONFIRM_COUNT)) begin
                    n_status = blm_pkg::ST_NORMAL;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run   <= '0;
            r_held       <= '0;
            r_low_run    <= '0;
            r_normal_run <= '0;
            r_status     <= blm_pkg::ST_UNDECIDED;
        end else if (i_advance) begin
            r_zero_run   <= n_zero_run;
            r_held       <= n_held;
            r_low_run    <= n_low_run;
            r_normal_run <= n_normal_run;
            r_status     <= n_status;
        end
    end

    assign o_result.battery_centivolts = w_volts;
    assign o_result.power_status       = n_status;
    assign o_result.zero_held          = w_held_flag;

endmodule

/* design/battery_level_monitor_unit.sv */
// Pipeline: an accepted sample is held in the input register, then loaded into the
// result register, which offers it on the master side. Throughput: one sample per
// cycle unless the master side stalls; the single-pass core between the input and
// result registers updates its state in the same cycle it produces a result.
// Reset: synchronous, active low; clears both stage valids, all run counters,
// the held voltage and status, and restores the limit registers to their defaults.
// ----------------------------------------------------------------------------
// Battery level monitor
// Converts battery ADC samples to centivolts and tracks low/normal power status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_level_monitor_unit #(
    parameter int unsigned CONFIRM_COUNT = blm_pkg::CONFIRM_COUNT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [9:0]  i_cfg_data,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] adc_sample
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [9:0] battery_centivolts, [11:10] power_status
    output logic [0:0]  m_axis_tuser    // [0] zero_held
);

    logic                               r_in_valid;
    logic [blm_pkg::SAMPLE_W-1:0]       r_sample;
    logic                               r_out_valid;
    blm_pkg::t_result                   r_out;
    blm_pkg::t_limits                   r_limits;

    blm_pkg::t_result                   w_result;
    logic                               w_move;

    // Advance the input stage whenever the result register is free or being emptied
    assign w_move        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.high_limit <= blm_pkg::HIGH_LIMIT_RST;
            r_limits.low_limit  <= blm_pkg::LOW_LIMIT_RST;
            r_limits.off_limit  <= blm_pkg::OFF_LIMIT_RST;
            r_limits.zero_limit <= blm_pkg::ZERO_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (blm_pkg::t_cfg_index'(i_cfg_addr))
                blm_pkg::CFG_HIGH_LIMIT: r_limits.high_limit <= i_cfg_data;
                blm_pkg::CFG_LOW_LIMIT:  r_limits.low_limit  <= i_cfg_data;
                blm_pkg::CFG_OFF_LIMIT:  r_limits.off_limit  <= i_cfg_data;
                blm_pkg::CFG_ZERO_LIMIT: r_limits.zero_limit <= i_cfg_data[blm_pkg::ZLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_sample <= s_axis_tdata;
        end
        if (w_move) begin
            r_out <= w_result;
        end
    end

    blm_core #(
        .CONFIRM_COUNT (CONFIRM_COUNT)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_move),
        .i_sample  (r_sample),
        .i_limits  (r_limits),
        .o_result  (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out.power_status, r_out.battery_centivolts};
    assign m_axis_tuser  = r_out.zero_held;

endmodule

/* design/blm_checker.sv */
// ----------------------------------------------------------------------------
// Battery level monitor checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_level_monitor_unit_defines.svh"

module blm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // A stalled result must hold
    `BLM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed")

    // With the result side empty the input side must take a transfer
    `BLM_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready,
        "input stalled with empty result stage")

    // Voltage stays within full scale and status is a legal code
    `BLM_ASSERT_NOW(a_result_range, i_clk, i_rst_n, m_axis_tvalid,
        (m_axis_tdata[9:0] <= 10'd660) && (m_axis_tdata[11:10] != 2'd3)
            && (m_axis_tdata[15:12] == 4'd0),
        "result field out of range")

    // Once decided, status never returns to undecided
    `BLM_ASSERT_NEXT(a_status_sticky, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && (m_axis_tdata[11:10] != 2'd0),
        !m_axis_tvalid || (m_axis_tdata[11:10] != 2'd0),
        "status fell back to undecided")

endmodule

bind battery_level_monitor_unit blm_checker u_blm_checker (.*);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level monitor testbench
// Streams ADC readings through the unit under random source gaps and sink
// stalls. A local model of the zero hold, the limit judgement and the run
// counters predicts every result, and each received transfer is checked field
// by field against the oldest prediction.
// ----------------------------------------------------------------------------

module tb;

    localparam int IDLE_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [9:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] adc_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [9:0] battery_centivolts, [11:10] power_status
    logic [0:0]  m_axis_tuser;   // [0] zero_held

    battery_level_monitor_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // limits as the unit should hold them
    logic [blm_pkg::LIMIT_W-1:0] lim_high;
    logic [blm_pkg::LIMIT_W-1:0] lim_low;
    logic [blm_pkg::LIMIT_W-1:0] lim_off;
    logic [blm_pkg::ZLIM_W-1:0]  lim_zero;

    // battery state as the unit should hold it
    logic [blm_pkg::RUN_W-1:0]   zero_run;
    logic [blm_pkg::CV_W-1:0]    held_cv;
    logic [blm_pkg::RUN_W-1:0]   low_run;
    logic [blm_pkg::RUN_W-1:0]   normal_run;
    blm_pkg::t_power_status      status_now;

    blm_pkg::t_result expected_readings[$];

    int  mismatch_count;
    int  idle_cycles;
    bit  gaps_on;
    bit  stalls_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [blm_pkg::RUN_W-1:0] bump_run(
            input logic [blm_pkg::RUN_W-1:0] v);
        return (v == {blm_pkg::RUN_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    // advance the battery state by one reading and return the result it gives
    function automatic blm_pkg::t_result predict_reading(
            input logic [blm_pkg::SAMPLE_W-1:0] sample);
        blm_pkg::t_result r;
        int unsigned      cv;
        logic             held;
        cv   = (int'(sample) * blm_pkg::CV_FULL_SCALE) / blm_pkg::ADC_FULL_SCALE;
        held = 1'b0;
        if (cv == 0) begin
            zero_run = bump_run(zero_run);
            if (zero_run >= lim_zero) begin
                held_cv = '0;
            end else begin
                cv   = 32'(held_cv);
                held = 1'b1;
            end
        end else begin
            zero_run = '0;
            held_cv  = cv[blm_pkg::CV_W-1:0];
        end
        if (cv <= lim_high) begin
            if (cv <= lim_low) begin
                normal_run = '0;
                if (cv > lim_off) begin
                    low_run = bump_run(low_run);
                    if (low_run >= blm_pkg::CONFIRM_COUNT) status_now = blm_pkg::ST_LOW;
                end
            end else begin
                low_run    = '0;
                normal_run = bump_run(normal_run);
                if (normal_run >= blm_pkg::CONFIRM_COUNT) status_now = blm_pkg::ST_NORMAL;
            end
        end
        r.battery_centivolts = cv[blm_pkg::CV_W-1:0];
        r.power_status       = status_now;
        r.zero_held          = held;
        return r;
    endfunction

    // sink side: random stall bursts while enabled
    initial begin
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result check and watchdog
    always @(posedge i_clk) begin
        blm_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_readings.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: cv %0d status %0d held %0d",
                             m_axis_tdata[9:0], m_axis_tdata[11:10], m_axis_tuser[0]);
                mismatch_count++;
            end else begin
                want = expected_readings.pop_front();
                if (m_axis_tdata[9:0] !== want.battery_centivolts ||
                    m_axis_tdata[11:10] !== want.power_status ||
                    m_axis_tuser[0] !== want.zero_held) begin
                    if (mismatch_count < 10)
                        $display("mismatch: cv %0d/%0d status %0d/%0d held %0d/%0d (exp/got)",
                                 want.battery_centivolts, m_axis_tdata[9:0],
                                 want.power_status, m_axis_tdata[11:10],
                                 want.zero_held, m_axis_tuser[0]);
                    mismatch_count++;
                end
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_sample(input logic [blm_pkg::SAMPLE_W-1:0] sample);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_readings.push_back(predict_reading(sample));
    endtask

    // drop valid and wait until every result is back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [blm_pkg::LIMIT_W-1:0] high,
                              input logic [blm_pkg::LIMIT_W-1:0] low,
                              input logic [blm_pkg::LIMIT_W-1:0] off,
                              input logic [blm_pkg::ZLIM_W-1:0]  zlim);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= blm_pkg::CFG_HIGH_LIMIT;
        i_cfg_data <= high;
        @(posedge i_clk);
        i_cfg_addr <= blm_pkg::CFG_LOW_LIMIT;
        i_cfg_data <= low;
        @(posedge i_clk);
        i_cfg_addr <= blm_pkg::CFG_OFF_LIMIT;
        i_cfg_data <= off;
        @(posedge i_clk);
        i_cfg_addr <= blm_pkg::CFG_ZERO_LIMIT;
        i_cfg_data <= {2'b00, zlim};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        lim_high = high;
        lim_low  = low;
        lim_off  = off;
        lim_zero = zlim;
    endtask

    // reset limits: confirm normal, hold zeros, accept the third, confirm low
    task automatic test_default_limits();
        repeat (3) send_sample(8'd255);
        repeat (3) send_sample(8'd0);
        send_sample(8'd1);
        send_sample(8'd128);
        send_sample(8'd129);
        send_sample(8'd130);
    endtask

    task automatic test_zero_limit_edges();
        // a zero limit of zero takes a zero at once; a limit of one too
        set_limits(10'd660, 10'd360, 10'd330, 8'd0);
        send_sample(8'd200);
        send_sample(8'd0);
        set_limits(10'd660, 10'd360, 10'd330, 8'd1);
        send_sample(8'd127);
        send_sample(8'd0);
        send_sample(8'd0);
    endtask

    // limits out of order, at the ends of their range
    task automatic test_limit_order();
        set_limits(10'd0, 10'd1023, 10'd1023, 8'd255);
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd64);
        set_limits(10'd1023, 10'd0, 10'd1023, 8'd2);
        send_sample(8'd255);
        send_sample(8'd170);
        send_sample(8'd85);
        send_sample(8'd1);
    endtask

    // long runs to drive every run counter into saturation: held zeros repeat a
    // low-band voltage, so the zero run and the low run both saturate
    task automatic test_run_saturation();
        set_limits(10'd660, 10'd360, 10'd330, 8'd255);
        repeat (3) send_sample(8'd130);
        repeat (258) send_sample(8'd0);
        repeat (260) send_sample(8'd255);
    endtask

    task automatic pick_limits();
        logic [blm_pkg::LIMIT_W-1:0] high;
        logic [blm_pkg::LIMIT_W-1:0] low;
        logic [blm_pkg::LIMIT_W-1:0] off;
        logic [blm_pkg::ZLIM_W-1:0]  zlim;
        int unsigned                 sum;
        case ($urandom_range(0, 5))
            0: begin
                high = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                low  = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                off  = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
                zlim = $urandom_range(0, 1) ? 8'd255 : 8'd1;
            end
            1: begin
                high = 10'($urandom_range(0, 1023));
                low  = 10'($urandom_range(0, 1023));
                off  = 10'($urandom_range(0, 1023));
                zlim = 8'($urandom_range(0, 255));
            end
            default: begin
                off  = 10'($urandom_range(0, 600));
                low  = off + 10'($urandom_range(1, 200));
                sum  = 32'(low) + $urandom_range(1, 300);
                high = (sum > 1023) ? 10'd1023 : sum[blm_pkg::LIMIT_W-1:0];
                zlim = 8'($urandom_range(1, 6));
            end
        endcase
        set_limits(high, low, off, zlim);
    endtask

    // bursts: runs of zeros, steady readings with jitter, odd single readings
    task automatic send_random_bursts(input int count);
        int sent;
        int len;
        int base;
        int val;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    len = $urandom_range(1, (lim_zero > 10) ? 12 : int'(lim_zero) + 2);
                    repeat (len) send_sample(8'd0);
                    sent += len;
                end
                8, 9: begin
                    send_sample(8'($urandom_range(0, 255)));
                    sent++;
                end
                default: begin
                    len  = $urandom_range(1, 6);
                    base = $urandom_range(0, 255);
                    repeat (len) begin
                        val = base + int'($urandom_range(0, 4)) - 2;
                        if (val < 0) val = 0;
                        if (val > 255) val = 255;
                        send_sample(val[7:0]);
                    end
                    sent += len;
                end
            endcase
        end
    endtask

    task automatic test_random_traffic();
        repeat (6) begin
            pick_limits();
            send_random_bursts(40);
        end
        // closing stretch at full rate
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        pick_limits();
        send_random_bursts(60);
    endtask

    initial begin
        mismatch_count = 0;
        idle_cycles    = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        lim_high   = blm_pkg::HIGH_LIMIT_RST;
        lim_low    = blm_pkg::LOW_LIMIT_RST;
        lim_off    = blm_pkg::OFF_LIMIT_RST;
        lim_zero   = blm_pkg::ZERO_LIMIT_RST;
        zero_run   = '0;
        held_cv    = '0;
        low_run    = '0;
        normal_run = '0;
        status_now = blm_pkg::ST_UNDECIDED;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= blm_pkg::CFG_HIGH_LIMIT;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_limits();
        test_zero_limit_edges();
        test_limit_order();
        test_run_saturation();
        test_random_traffic();

        settle();
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
